[rtl/mpvr_pkg.sv]
// mpvr_pkg: shared widths, register indexes, reset values and lane result type
// for the multi-point vacuum valve regulator. No dependencies.
`timescale 1ns / 1ps

package mpvr_pkg;

  // channel ports and default active channel count
  localparam int NUM_PORTS    = 4;
  localparam int CHANNELS_DEF = 2;

  // field widths
  localparam int RAW_W      = 12;
  localparam int P_W        = 12;
  localparam int TGT_W      = 12;
  localparam int DB_W       = 8;
  localparam int TICK_W     = 16;
  localparam int POS_W      = TICK_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Q16 pressure gain: round(65536 * 3.3 * 1000 / (2.7 * 4095))
  localparam int           GAIN_W = 15;
  localparam logic [GAIN_W-1:0] PRESSURE_GAIN = 15'd19560;
  localparam int FRAC_W = 16;
  localparam int PROD_W = RAW_W + GAIN_W;
  // signed compare width: holds -(product) and (target +/- deadband) << 16
  localparam int CMP_W  = PROD_W + 3;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_CH0    = 3'd0,
    REG_TARGET_CH1    = 3'd1,
    REG_TARGET_CH2    = 3'd2,
    REG_TARGET_CH3    = 3'd3,
    REG_DEADBAND      = 3'd4,
    REG_SUCTION_TICKS = 3'd5,
    REG_RELEASE_TICKS = 3'd6
  } reg_idx_e;

  // register reset values
  localparam logic signed [TGT_W-1:0] TARGET0_RST  = 12'sd0;
  localparam logic signed [TGT_W-1:0] TARGET1_RST  = -12'sd500;
  localparam logic signed [TGT_W-1:0] TARGET2_RST  = -12'sd300;
  localparam logic signed [TGT_W-1:0] TARGET3_RST  = -12'sd300;
  localparam logic [DB_W-1:0]         DEADBAND_RST = 8'd20;
  localparam logic [TICK_W-1:0]       SUCTION_RST  = 16'd3000;
  localparam logic [TICK_W-1:0]       RELEASE_RST  = 16'd2000;

  // per-lane decision
  typedef struct packed {
    logic                  suck;
    logic                  rel;
    logic signed [P_W-1:0] pressure;
  } lane_res_t;

endpackage

[rtl/mpvr_lane.sv]
// mpvr_lane: one suction point; registers the Q16 pressure product and
// compares it against the deadband limits. Depends on mpvr_pkg.
`timescale 1ns / 1ps

module mpvr_lane import mpvr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic [RAW_W-1:0]        raw_i,
  input  logic signed [TGT_W-1:0] target_i,
  input  logic [DB_W-1:0]         deadband_i,
  output lane_res_t               res_o
);

  logic [PROD_W-1:0]       prod_d, prod_q;
  logic signed [CMP_W-1:0] pq, tgt_x, db_x, hi, lo;

  // raw sample times gain, one register before the compares
  assign prod_d = PROD_W'(raw_i) * PROD_W'(PRESSURE_GAIN);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // band limits in Q16 and the negated pressure
  always_comb begin
    pq    = -$signed(CMP_W'(prod_q));
    tgt_x = {{(CMP_W-TGT_W){target_i[TGT_W-1]}}, target_i};
    db_x  = $signed(CMP_W'(deadband_i));
    hi    = (tgt_x + db_x) <<< FRAC_W;
    lo    = (tgt_x - db_x) <<< FRAC_W;
  end

  // valve decision and truncated pressure
  always_comb begin
    res_o.suck     = (pq >= hi);
    res_o.rel      = (pq < lo);
    res_o.pressure = -$signed({1'b0, prod_q[PROD_W-1:FRAC_W]});
  end

endmodule

[rtl/mpvr_merge.sv]
// mpvr_merge: combines lane decisions into valve masks and pump level and
// holds the output item register. Depends on mpvr_pkg.
`timescale 1ns / 1ps

module mpvr_merge import mpvr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  release_phase_i,
  input  lane_res_t             lane_res_i [NUM_PORTS],
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [NUM_PORTS-1:0]  suction_mask_o,
  output logic [NUM_PORTS-1:0]  release_mask_o,
  output logic                  pump_valve_o,
  output logic                  release_phase_o,
  output logic signed [P_W-1:0] pressure_o [NUM_PORTS]
);

  logic [NUM_PORTS-1:0]  active, smask, rmask;
  logic                  out_valid_d, out_valid_q;
  logic [NUM_PORTS-1:0]  smask_d, smask_q, rmask_d, rmask_q;
  logic                  pump_d, pump_q, phase_q;
  logic signed [P_W-1:0] press_q [NUM_PORTS];

  // collect lane bits, masked to the active channels
  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      active[i] = (i < CHANNELS);
      smask[i]  = lane_res_i[i].suck & active[i];
      rmask[i]  = lane_res_i[i].rel & active[i];
    end
  end

  // phase selects regulated or forced release outputs
  always_comb begin
    if (release_phase_i) begin
      smask_d = '0;
      rmask_d = active;
      pump_d  = 1'b1;
    end else begin
      smask_d = smask;
      rmask_d = rmask;
      pump_d  = ~(|smask);
    end
  end

  // output valid flag
  assign out_valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output item payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      smask_q <= smask_d;
      rmask_q <= rmask_d;
      pump_q  <= pump_d;
      phase_q <= release_phase_i;
      for (int i = 0; i < NUM_PORTS; i++) begin
        press_q[i] <= lane_res_i[i].pressure;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign suction_mask_o  = smask_q;
  assign release_mask_o  = rmask_q;
  assign pump_valve_o    = pump_q;
  assign release_phase_o = phase_q;
  assign pressure_o      = press_q;

endmodule

[rtl/multi_point_vacuum_valve_regulator_unit.sv]
// multi_point_vacuum_valve_regulator_unit: top level with config registers,
// tick phase counter, one lane per active channel and the merge stage.
// Depends on mpvr_pkg, mpvr_lane, mpvr_merge.
// Pipeline: an accepted input is registered in the lane product stage, then the
// merge stage loads the output register and raises output valid (product, then merge).
// Throughput: one item per cycle; the two-stage pipeline only stalls when the
// output register is full and not taken.
// Reset: clears the tick position and pipeline valid flags and loads the
// register defaults; no clearing pass.
`timescale 1ns / 1ps

module multi_point_vacuum_valve_regulator_unit import mpvr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // input item
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RAW_W-1:0]        sample_0_i,
  input  logic [RAW_W-1:0]        sample_1_i,
  input  logic [RAW_W-1:0]        sample_2_i,
  input  logic [RAW_W-1:0]        sample_3_i,
  // result item
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [NUM_PORTS-1:0]    suction_mask_o,
  output logic [NUM_PORTS-1:0]    release_mask_o,
  output logic                    pump_valve_o,
  output logic                    release_phase_o,
  output logic signed [P_W-1:0]   pressure_0_o,
  output logic signed [P_W-1:0]   pressure_1_o,
  output logic signed [P_W-1:0]   pressure_2_o,
  output logic signed [P_W-1:0]   pressure_3_o
);

  logic signed [TGT_W-1:0] target_q [NUM_PORTS];
  logic [DB_W-1:0]         deadband_q;
  logic [TICK_W-1:0]       suction_q, release_q;
  logic [POS_W-1:0]        pos_q, pos_inc, pos_d, period;
  logic                    s1_valid_q, phase_q, phase_d;
  logic                    in_acc, s1_move, out_valid;
  logic [RAW_W-1:0]        raw [NUM_PORTS];
  lane_res_t               lane_res [NUM_PORTS];
  logic signed [P_W-1:0]   press [NUM_PORTS];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q[0] <= TARGET0_RST;
      target_q[1] <= TARGET1_RST;
      target_q[2] <= TARGET2_RST;
      target_q[3] <= TARGET3_RST;
      deadband_q  <= DEADBAND_RST;
      suction_q   <= SUCTION_RST;
      release_q   <= RELEASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_CH0:    target_q[0] <= cfg_data_i[TGT_W-1:0];
        REG_TARGET_CH1:    target_q[1] <= cfg_data_i[TGT_W-1:0];
        REG_TARGET_CH2:    target_q[2] <= cfg_data_i[TGT_W-1:0];
        REG_TARGET_CH3:    target_q[3] <= cfg_data_i[TGT_W-1:0];
        REG_DEADBAND:      deadband_q  <= cfg_data_i[DB_W-1:0];
        REG_SUCTION_TICKS: suction_q   <= cfg_data_i[TICK_W-1:0];
        REG_RELEASE_TICKS: release_q   <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: stage one feeds the output register
  assign s1_move    = s1_valid_q & (~out_valid | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_move;
  assign in_acc     = in_valid_i & in_ready_o;

  // tick position: increment, wrap at the period, then pick the phase
  always_comb begin
    period  = POS_W'(suction_q) + POS_W'(release_q);
    pos_inc = pos_q + POS_W'(1);
    pos_d   = (pos_inc >= period) ? '0 : pos_inc;
    phase_d = ~(pos_d < POS_W'(suction_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_q <= pos_d;
      end
      s1_valid_q <= in_acc | (s1_valid_q & ~s1_move);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      phase_q <= phase_d;
    end
  end

  assign raw[0] = sample_0_i;
  assign raw[1] = sample_1_i;
  assign raw[2] = sample_2_i;
  assign raw[3] = sample_3_i;

  // one lane per active channel, idle ports read as zero
  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      mpvr_lane u_lane (
        .clk_i      (clk_i),
        .load_i     (in_acc),
        .raw_i      (raw[g]),
        .target_i   (target_q[g]),
        .deadband_i (deadband_q),
        .res_o      (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  // merge lanes into the output item
  mpvr_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (s1_move),
    .release_phase_i (phase_q),
    .lane_res_i      (lane_res),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid),
    .suction_mask_o  (suction_mask_o),
    .release_mask_o  (release_mask_o),
    .pump_valve_o    (pump_valve_o),
    .release_phase_o (release_phase_o),
    .pressure_o      (press)
  );

  assign out_valid_o  = out_valid;
  assign pressure_0_o = press[0];
  assign pressure_1_o = press[1];
  assign pressure_2_o = press[2];
  assign pressure_3_o = press[3];

endmodule
